// ===== design/gpio_rb_pkg.sv =====
// Package: register map, codes and stream item layouts for the GPIO register block.
`default_nettype none
package gpio_rb_pkg;

  localparam int WORD_W = 6;
  localparam int DATA_W = 32;
  localparam int PAD_W = 28;
  localparam int FIELD_W = 3;
  localparam int PINS_PER_WORD = 10;

  localparam logic [WORD_W-1:0] FSEL_WORDS = 6'd6;
  localparam logic [WORD_W-1:0] WORD_SET = 6'd7;
  localparam logic [WORD_W-1:0] WORD_CLR = 6'd10;
  localparam logic [WORD_W-1:0] WORD_LEV = 6'd13;
  localparam logic [WORD_W-1:0] WORD_PUD = 6'd37;
  localparam logic [WORD_W-1:0] WORD_PUDCLK = 6'd38;

  localparam logic [FIELD_W-1:0] FUNC_OUTPUT = 3'd1;
  localparam logic [1:0] PULL_DOWN_CODE = 2'd1;
  localparam logic [1:0] PULL_UP_CODE = 2'd2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Input transaction, 72 bits, op in bit 0.
  typedef struct packed {
    logic [4:0]        fill;
    logic [PAD_W-1:0]  pad_levels;
    logic [DATA_W-1:0] write_data;
    logic [WORD_W-1:0] word_index;
    op_t               op;
  } in_item_t;

  // Result transaction, 144 bits, read_data in the low word.
  typedef struct packed {
    logic [PAD_W-1:0]  pull_down_enables;
    logic [PAD_W-1:0]  pull_up_enables;
    logic [PAD_W-1:0]  drive_enables;
    logic [PAD_W-1:0]  drive_values;
    logic [DATA_W-1:0] read_data;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/gpio_register_block.sv =====
// GPIO register block: top level with input register, register file and result register.
`default_nettype none
// One bus access per transaction: a read or write to a word offset (0-5 function
// select, 7 set, 10 clear, 13 level, 37 pull control, 38 pull clock) plus the
// sampled pad levels. Each transaction returns one result holding the read data
// and the drive and pull outputs after the access. The block takes one
// transaction every clock cycle unless back-pressure stalls it; an accepted
// transaction is held in the input register and then in the result register,
// which presents the result. Result-side back-pressure stalls both registers.
module gpio_register_block #(
  parameter int PIN_COUNT = 28
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // op[0], word_index[6:1], write_data[38:7], pad_levels[66:39], zero fill
  input  wire  [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // read_data[31:0], drive_values[59:32], drive_enables[87:60],
  // pull_up_enables[115:88], pull_down_enables[143:116]
  output logic [143:0] m_axis_tdata
);

  localparam int FW = gpio_rb_pkg::FIELD_W;
  localparam int DW = gpio_rb_pkg::DATA_W;
  localparam int PW = gpio_rb_pkg::PAD_W;

  gpio_rb_pkg::in_item_t  in_reg;
  gpio_rb_pkg::out_item_t out_reg;
  gpio_rb_pkg::out_item_t out_next;
  logic                   in_valid;
  logic                   advance;
  logic                   commit;
  logic                   wr;

  logic [FW-1:0]          fsel [PIN_COUNT];
  logic [FW-1:0]          fsel_next [PIN_COUNT];
  logic [1:0]             pull_state [PIN_COUNT];
  logic [1:0]             pull_state_next [PIN_COUNT];
  logic [DW-1:0]          fsel_rd_part [PIN_COUNT];
  logic [PIN_COUNT-1:0]   output_latch;
  logic [PIN_COUNT-1:0]   output_latch_next;
  logic [1:0]             pull_control;
  logic [1:0]             pull_control_next;
  logic [PIN_COUNT-1:0]   en_cur;
  logic [PIN_COUNT-1:0]   en_next;
  logic [PIN_COUNT-1:0]   up_next;
  logic [PIN_COUNT-1:0]   dn_next;
  logic [PIN_COUNT-1:0]   pads;
  logic [PIN_COUNT-1:0]   wdata_pins;
  logic [DW-1:0]          fsel_rd;
  logic [DW-1:0]          read_data;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign commit        = in_valid && advance;
  assign wr            = (in_reg.op == gpio_rb_pkg::OP_WRITE);
  assign m_axis_tdata  = out_reg;

  assign pads       = PIN_COUNT'(DW'(in_reg.pad_levels));
  assign wdata_pins = in_reg.write_data[PIN_COUNT-1:0];

  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    localparam int Word = p / gpio_rb_pkg::PINS_PER_WORD;
    localparam int Lsb = (p % gpio_rb_pkg::PINS_PER_WORD) * FW;
    logic hit;
    assign hit = (in_reg.word_index == gpio_rb_pkg::WORD_W'(Word));
    assign fsel_next[p] = (hit && wr) ? in_reg.write_data[Lsb +: FW] : fsel[p];
    assign fsel_rd_part[p] = (hit && !wr) ? (DW'(fsel[p]) << Lsb) : '0;
    assign pull_state_next[p] =
      (wr && in_reg.word_index == gpio_rb_pkg::WORD_PUDCLK && in_reg.write_data[p])
        ? pull_control : pull_state[p];
    assign en_cur[p]  = (fsel[p] == gpio_rb_pkg::FUNC_OUTPUT);
    assign en_next[p] = (fsel_next[p] == gpio_rb_pkg::FUNC_OUTPUT);
    assign up_next[p] = (pull_state_next[p] == gpio_rb_pkg::PULL_UP_CODE);
    assign dn_next[p] = (pull_state_next[p] == gpio_rb_pkg::PULL_DOWN_CODE);
  end

  always_comb begin
    fsel_rd = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      fsel_rd = fsel_rd | fsel_rd_part[p];
    end
  end

  always_comb begin
    output_latch_next = output_latch;
    pull_control_next = pull_control;
    read_data         = '0;
    if (wr) begin
      unique case (in_reg.word_index)
        gpio_rb_pkg::WORD_SET: output_latch_next = output_latch | wdata_pins;
        gpio_rb_pkg::WORD_CLR: output_latch_next = output_latch & ~wdata_pins;
        gpio_rb_pkg::WORD_PUD: pull_control_next = in_reg.write_data[1:0];
        default: ;
      endcase
    end else if (in_reg.word_index < gpio_rb_pkg::FSEL_WORDS) begin
      read_data = fsel_rd;
    end else begin
      unique case (in_reg.word_index)
        gpio_rb_pkg::WORD_LEV: read_data = DW'((output_latch & en_cur) | (pads & ~en_cur));
        gpio_rb_pkg::WORD_PUD: read_data = DW'(pull_control);
        default: ;
      endcase
    end
    out_next.read_data         = read_data;
    out_next.drive_values      = PW'(DW'(output_latch_next));
    out_next.drive_enables     = PW'(DW'(en_next));
    out_next.pull_up_enables   = PW'(DW'(up_next));
    out_next.pull_down_enables = PW'(DW'(dn_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_reg <= gpio_rb_pkg::in_item_t'(s_axis_tdata);
    end
    if (commit) begin
      out_reg <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_latch <= '0;
      pull_control <= '0;
      for (int p = 0; p < PIN_COUNT; p++) begin
        fsel[p]       <= '0;
        pull_state[p] <= '0;
      end
    end else if (commit) begin
      output_latch <= output_latch_next;
      pull_control <= pull_control_next;
      for (int p = 0; p < PIN_COUNT; p++) begin
        fsel[p]       <= fsel_next[p];
        pull_state[p] <= pull_state_next[p];
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_axis_tvalid)
    else $error("committed transaction produced no result");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (commit && wr) |=> (m_axis_tdata[31:0] == '0))
    else $error("write transaction returned nonzero read data");

  a_pull_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[115:88] & m_axis_tdata[143:116]) == '0))
    else $error("pin has both pull-up and pull-down");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for gpio_register_block: stream driver, result monitor and register predictor.
`timescale 1ns / 1ps
module tb;

  localparam int PINS = 28;

  typedef struct {
    gpio_rb_pkg::in_item_t item;
    int                    gap;
    bit                    drain;
  } pending_access_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  gpio_register_block uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow copy of the register file
  logic [2:0]      shadow_fsel [PINS];
  logic [PINS-1:0] shadow_latch;
  logic [1:0]      shadow_pull_code;
  logic [1:0]      shadow_pull_state [PINS];

  pending_access_t        pending_accesses[$];
  gpio_rb_pkg::out_item_t expected_results[$];
  pending_access_t        next_access;
  gpio_rb_pkg::out_item_t predicted;
  gpio_rb_pkg::out_item_t observed;

  int total_items = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int error_count = 0;
  int result_wait = 0;
  int gap_phase = 0;
  bit drain_flag = 1'b0;
  bit drained = 1'b0;
  logic rx_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap(input int phase);
    case (phase)
      1: return 0;
      2: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] expv,
                                 input logic [31:0] gotv);
    $display("MISMATCH %s: expected %h, got %h (result %0d)", what, expv, gotv,
             results_seen);
    error_count++;
  endtask

  task automatic predict_access(input gpio_rb_pkg::in_item_t a,
                                output gpio_rb_pkg::out_item_t r);
    int p;
    logic [PINS-1:0] en;
    r = '0;
    if (a.op == gpio_rb_pkg::OP_WRITE) begin
      if (a.word_index < gpio_rb_pkg::FSEL_WORDS) begin
        for (int k = 0; k < gpio_rb_pkg::PINS_PER_WORD; k++) begin
          p = int'(a.word_index) * gpio_rb_pkg::PINS_PER_WORD + k;
          if (p < PINS) shadow_fsel[p] = a.write_data[k*3 +: 3];
        end
      end else if (a.word_index == gpio_rb_pkg::WORD_SET) begin
        shadow_latch = shadow_latch | a.write_data[PINS-1:0];
      end else if (a.word_index == gpio_rb_pkg::WORD_CLR) begin
        shadow_latch = shadow_latch & ~a.write_data[PINS-1:0];
      end else if (a.word_index == gpio_rb_pkg::WORD_PUD) begin
        shadow_pull_code = a.write_data[1:0];
      end else if (a.word_index == gpio_rb_pkg::WORD_PUDCLK) begin
        for (int q = 0; q < PINS; q++)
          if (a.write_data[q]) shadow_pull_state[q] = shadow_pull_code;
      end
    end
    for (int q = 0; q < PINS; q++) en[q] = (shadow_fsel[q] == gpio_rb_pkg::FUNC_OUTPUT);
    if (a.op == gpio_rb_pkg::OP_READ) begin
      if (a.word_index < gpio_rb_pkg::FSEL_WORDS) begin
        for (int k = 0; k < gpio_rb_pkg::PINS_PER_WORD; k++) begin
          p = int'(a.word_index) * gpio_rb_pkg::PINS_PER_WORD + k;
          if (p < PINS) r.read_data[k*3 +: 3] = shadow_fsel[p];
        end
      end else if (a.word_index == gpio_rb_pkg::WORD_LEV) begin
        r.read_data[PINS-1:0] = (shadow_latch & en) | (a.pad_levels & ~en);
      end else if (a.word_index == gpio_rb_pkg::WORD_PUD) begin
        r.read_data[1:0] = shadow_pull_code;
      end
    end
    r.drive_values = shadow_latch;
    r.drive_enables = en;
    for (int q = 0; q < PINS; q++) begin
      r.pull_up_enables[q] = (shadow_pull_state[q] == gpio_rb_pkg::PULL_UP_CODE);
      r.pull_down_enables[q] = (shadow_pull_state[q] == gpio_rb_pkg::PULL_DOWN_CODE);
    end
  endtask

  task automatic queue_access(input gpio_rb_pkg::op_t op, input logic [5:0] idx,
                              input logic [31:0] data, input logic [27:0] pads);
    pending_access_t e;
    e.item = '0;
    e.item.op = op;
    e.item.word_index = idx;
    e.item.write_data = data;
    e.item.pad_levels = pads;
    e.gap = pick_gap(gap_phase);
    e.drain = drain_flag;
    drain_flag = 1'b0;
    pending_accesses.push_back(e);
    total_items++;
  endtask

  task automatic add_random_accesses();
    logic [31:0] d;
    logic [27:0] pads;
    gpio_rb_pkg::op_t op;
    int sel;
    d = $urandom;
    pads = 28'($urandom);
    op = $urandom_range(0, 1) ? gpio_rb_pkg::OP_WRITE : gpio_rb_pkg::OP_READ;
    sel = $urandom_range(0, 19);
    if (sel <= 4) begin
      for (int k = 0; k < gpio_rb_pkg::PINS_PER_WORD; k++)
        case ($urandom_range(0, 3)) inside
          0: d[k*3 +: 3] = 3'd0;
          1, 2: d[k*3 +: 3] = gpio_rb_pkg::FUNC_OUTPUT;
          default: ;
        endcase
      queue_access(op, 6'($urandom_range(0, 5)), d, pads);
    end else if (sel <= 6) begin
      queue_access(($urandom_range(0, 5) == 0) ? gpio_rb_pkg::OP_READ : gpio_rb_pkg::OP_WRITE,
                   gpio_rb_pkg::WORD_SET, d, pads);
    end else if (sel <= 8) begin
      queue_access(($urandom_range(0, 5) == 0) ? gpio_rb_pkg::OP_READ : gpio_rb_pkg::OP_WRITE,
                   gpio_rb_pkg::WORD_CLR, d, pads);
    end else if (sel <= 11) begin
      queue_access((sel == 11) ? op : gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_LEV, d, pads);
    end else if (sel <= 14) begin
      // pull setup: code, clock it into some pins, read the code back
      queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUD, d, pads);
      queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUDCLK, $urandom,
                   28'($urandom));
      queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_PUD, $urandom, 28'($urandom));
    end else if (sel <= 16) begin
      queue_access(gpio_rb_pkg::OP_READ, 6'($urandom_range(0, 5)), d, pads);
    end else begin
      queue_access(op, 6'($urandom_range(0, 63)), d, pads);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_access(gpio_rb_pkg::in_item_t'(s_axis_tdata), predicted);
        expected_results.push_back(predicted);
        accepted_count++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // transaction still on offer
      end else if (pending_accesses.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_accesses[0].gap > 0) begin
        pending_accesses[0].gap = pending_accesses[0].gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_accesses[0].drain && expected_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        next_access = pending_accesses.pop_front();
        s_axis_tdata <= next_access.item;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        observed = gpio_rb_pkg::out_item_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result read_data", '0, observed.read_data);
        end else begin
          predicted = expected_results.pop_front();
          if (observed.read_data !== predicted.read_data)
            report_mismatch("read_data", predicted.read_data, observed.read_data);
          if (observed.drive_values !== predicted.drive_values)
            report_mismatch("drive_values", 32'(predicted.drive_values),
                            32'(observed.drive_values));
          if (observed.drive_enables !== predicted.drive_enables)
            report_mismatch("drive_enables", 32'(predicted.drive_enables),
                            32'(observed.drive_enables));
          if (observed.pull_up_enables !== predicted.pull_up_enables)
            report_mismatch("pull_up_enables", 32'(predicted.pull_up_enables),
                            32'(observed.pull_up_enables));
          if (observed.pull_down_enables !== predicted.pull_down_enables)
            report_mismatch("pull_down_enables", 32'(predicted.pull_down_enables),
                            32'(observed.pull_down_enables));
        end
        result_wait = pick_gap((results_seen / 100) % 4);
      end
      if (result_wait > 0) begin
        result_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rx_hold;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    while (results_seen < 200) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    for (int q = 0; q < PINS; q++) begin
      shadow_fsel[q] = '0;
      shadow_pull_state[q] = '0;
    end
    shadow_latch = '0;
    shadow_pull_code = '0;

    queue_access(gpio_rb_pkg::OP_READ, 6'd0, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd0, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, 6'd0, 32'h0, 28'hFFF_FFFF);
    // pins past the last one: fields ignored
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd2, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, 6'd2, 32'h0, 28'h0);
    // word with no pins
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd5, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, 6'd5, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd0, 32'h0924_9249, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd1, 32'h0924_9249, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd2, 32'h0924_9249, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_SET, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_LEV, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_CLR, 32'h0000_FFFF, 28'hFFF_FFFF);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_LEV, 32'hFFFF_FFFF, 28'hFFF_FFFF);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd1, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_LEV, 32'h0, 28'h555_5555);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_SET, 32'h0, 28'h0);
    // pull code 3 latches but gives no pull
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUD, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_PUD, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUDCLK, 32'hFFFF_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUD,
                 32'(gpio_rb_pkg::PULL_UP_CODE), 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUDCLK, 32'h0000_FFFF, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUD,
                 32'(gpio_rb_pkg::PULL_DOWN_CODE), 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, gpio_rb_pkg::WORD_PUDCLK, 32'hFFFF_0000, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, gpio_rb_pkg::WORD_PUDCLK, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_READ, 6'd63, 32'h0, 28'h0);
    queue_access(gpio_rb_pkg::OP_WRITE, 6'd63, 32'hFFFF_FFFF, 28'hFFF_FFFF);

    while (total_items < 625) begin
      gap_phase = (total_items / 150) % 4;
      if (total_items >= 320 && !drained) begin
        drain_flag = 1'b1;
        drained = 1'b1;
      end
      add_random_accesses();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (accepted_count < total_items || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
